// ===== hw/rtl/rea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rea_pkg
// Shared types, codes and fixed-point helpers of the reprojection error
// accumulator.
// ----------------------------------------------------------------------------
package rea_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ROT_FRAC   = 30;
	// quotient bits per divide: rotation entries never exceed one
	localparam int ROT_STEPS  = ROT_FRAC + 2;
	localparam int ROT_SHIFT  = ROT_STEPS - ROT_FRAC - 1;
	// normalized coordinates: enough quotient bits to see a 32-bit overflow
	localparam int PRJ_STEPS  = 34;
	localparam int PRJ_SHIFT  = PRJ_STEPS - FRAC_BITS - 1;
	localparam int SQRT_STEPS = 32;

	localparam logic       REQ_POSE = 1'b0;
	localparam logic       REQ_OBS  = 1'b1;

	localparam logic [1:0] TRK_UNTRACKED = 2'd0;
	localparam logic [1:0] TRK_MISSING   = 2'd1;
	localparam logic [1:0] TRK_PRESENT   = 2'd2;

	localparam logic [1:0] CAM_SIMPLE  = 2'd0;
	localparam logic [1:0] CAM_PINHOLE = 2'd1;
	localparam logic [1:0] CAM_RADIAL  = 2'd2;

	localparam logic [2:0] STAT_POSE      = 3'd0;
	localparam logic [2:0] STAT_CHECKED   = 3'd1;
	localparam logic [2:0] STAT_UNTRACKED = 3'd2;
	localparam logic [2:0] STAT_MISSING   = 3'd3;
	localparam logic [2:0] STAT_BEHIND    = 3'd4;

	localparam logic [2:0] CFG_CAM_MODEL   = 3'd0;
	localparam logic [2:0] CFG_FOCAL_X     = 3'd1;
	localparam logic [2:0] CFG_FOCAL_Y     = 3'd2;
	localparam logic [2:0] CFG_PRINCIPAL_X = 3'd3;
	localparam logic [2:0] CFG_PRINCIPAL_Y = 3'd4;
	localparam logic [2:0] CFG_RADIAL_K    = 3'd5;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] obs_u;
		logic signed [31:0] obs_v;
		logic [1:0]         track_state;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] res_x;
		logic signed [31:0] res_y;
		logic signed [31:0] res_z;
		logic [31:0]        err_px;
		logic [31:0]        checked_count;
		logic [31:0]        missing_count;
		logic [31:0]        behind_count;
		logic [47:0]        err_sum;
		logic [31:0]        err_min;
		logic [31:0]        err_max;
	} out_item_t;

	// round to nearest, ties away from zero
	function automatic logic signed [65:0] rshift_round(logic signed [65:0] x, int n);
		logic [65:0] mag;
		logic [65:0] r;
		mag = x[65] ? 66'(-x) : 66'(x);
		r   = (mag + (66'd1 << (n - 1))) >> n;
		return x[65] ? -signed'(r) : signed'(r);
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [65:0] x);
		if (x > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -66'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

endpackage

// ===== hw/rtl/rea_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rea_ifs
// Request and response channels of the reprojection error accumulator.
// ----------------------------------------------------------------------------
interface rea_req_if;
	logic              valid;
	logic              ready;
	rea_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rea_rsp_if;
	logic               valid;
	logic               ready;
	rea_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/reprojection_error_accumulator.sv =====
`timescale 1ns / 1ps
// Requests are taken one at a time and share the divide / square-root unit (32 to 34
// quotient bits per divide, 32 root bits) and the one multiplier.
// Reset: asynchronous, active low; identity rotation, zero translation, cleared
// statistics, minimum error all ones, default camera registers.
// ----------------------------------------------------------------------------
// reprojection_error_accumulator
// Loads camera poses (returning the camera centre) and checks observations against
// them (returning the projected pixel and pixel error); all give error statistics.
// ----------------------------------------------------------------------------
module reprojection_error_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	rea_req_if.sink     req,
	rea_rsp_if.source   rsp
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PMUL = 4'd1;
	localparam logic [3:0] S_PSUM = 4'd2;
	localparam logic [3:0] S_PDLD = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_PDWR = 4'd5;
	localparam logic [3:0] S_DOT  = 4'd6;
	localparam logic [3:0] S_ZCHK = 4'd7;
	localparam logic [3:0] S_ODLD = 4'd8;
	localparam logic [3:0] S_ODWR = 4'd9;
	localparam logic [3:0] S_RAD  = 4'd10;
	localparam logic [3:0] S_PRJ  = 4'd11;
	localparam logic [3:0] S_SQRT = 4'd12;
	localparam logic [3:0] S_SQWR = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	localparam logic signed [31:0] ROT_ONE = 32'sd1 << rea_pkg::ROT_FRAC;

	logic [3:0]         state_q;
	logic [5:0]         cnt_q;
	logic [3:0]         idx_q;
	logic               pose_q;
	logic [2:0]         status_q;

	logic [1:0]         cam_model_q;
	logic [30:0]        focal_x_q;
	logic [30:0]        focal_y_q;
	logic signed [31:0] principal_x_q;
	logic signed [31:0] principal_y_q;
	logic signed [31:0] radial_k_q;

	logic signed [31:0] rot_q [9];
	logic signed [31:0] t0_q, t1_q, t2_q;
	logic signed [31:0] pvec_q [3];
	logic signed [31:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0] obs_u_q, obs_v_q;
	logic signed [63:0] qp_q [10];
	logic signed [63:0] s_q;

	logic signed [65:0] mul_q;
	logic signed [65:0] acc_q;
	logic signed [35:0] xc_q [3];
	logic signed [31:0] cen_q [3];

	logic [63:0]        rem_q;
	logic [63:0]        low_q;
	logic [63:0]        den_q;
	logic [33:0]        quo_q;
	logic               neg_q;
	logic               ovf_q;

	logic signed [31:0] xn_q, yn_q, rad_q, fxe_q, fye_q, u_q, v_q;
	logic [31:0]        r2_q, ax_q, ay_q, err_q;

	logic [31:0]        chk_q, mis_q, beh_q, emin_q, emax_q;
	logic [47:0]        sum_q;

	logic               out_valid_q;
	rea_pkg::out_item_t out_q;

	// ------------------------------------------------------------------------
	// shared multiplier
	// ------------------------------------------------------------------------
	logic [1:0]         dot_j;
	logic [1:0]         dot_i;
	logic [3:0]         ridx;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [31:0] tsel_j, tsel_i;

	assign dot_j = cnt_q[1:0];
	assign dot_i = idx_q[1:0];

	always_comb begin
		if (pose_q)
			ridx = {1'b0, dot_j, 1'b0} + {2'b00, dot_j} + {2'b00, dot_i};
		else
			ridx = {1'b0, dot_i, 1'b0} + {2'b00, dot_i} + {2'b00, dot_j};
	end

	always_comb begin
		case (dot_j)
			2'd0: tsel_j = t0_q;
			2'd1: tsel_j = t1_q;
			2'd2: tsel_j = t2_q;
			default: tsel_j = '0;
		endcase
		case (dot_i)
			2'd0: tsel_i = t0_q;
			2'd1: tsel_i = t1_q;
			2'd2: tsel_i = t2_q;
			default: tsel_i = '0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PMUL: begin
				case (cnt_q[3:0])
					4'd0: begin mul_a = {qw_q[31], qw_q}; mul_b = {qw_q[31], qw_q}; end
					4'd1: begin mul_a = {qx_q[31], qx_q}; mul_b = {qx_q[31], qx_q}; end
					4'd2: begin mul_a = {qy_q[31], qy_q}; mul_b = {qy_q[31], qy_q}; end
					4'd3: begin mul_a = {qz_q[31], qz_q}; mul_b = {qz_q[31], qz_q}; end
					4'd4: begin mul_a = {qx_q[31], qx_q}; mul_b = {qy_q[31], qy_q}; end
					4'd5: begin mul_a = {qz_q[31], qz_q}; mul_b = {qw_q[31], qw_q}; end
					4'd6: begin mul_a = {qx_q[31], qx_q}; mul_b = {qz_q[31], qz_q}; end
					4'd7: begin mul_a = {qy_q[31], qy_q}; mul_b = {qw_q[31], qw_q}; end
					4'd8: begin mul_a = {qy_q[31], qy_q}; mul_b = {qz_q[31], qz_q}; end
					4'd9: begin mul_a = {qx_q[31], qx_q}; mul_b = {qw_q[31], qw_q}; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_DOT: begin
				if (cnt_q < 6'd3) begin
					mul_a = {rot_q[ridx][31], rot_q[ridx]};
					if (pose_q)
						mul_b = {tsel_j[31], tsel_j};
					else
						mul_b = {pvec_q[dot_j][31], pvec_q[dot_j]};
				end
			end
			S_RAD: begin
				case (cnt_q)
					6'd0: begin mul_a = {xn_q[31], xn_q}; mul_b = {xn_q[31], xn_q}; end
					6'd1: begin mul_a = {yn_q[31], yn_q}; mul_b = {yn_q[31], yn_q}; end
					6'd3: begin mul_a = {radial_k_q[31], radial_k_q}; mul_b = {1'b0, r2_q}; end
					6'd5: begin mul_a = {2'b00, focal_x_q}; mul_b = {rad_q[31], rad_q}; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_PRJ: begin
				case (cnt_q)
					6'd0: begin mul_a = {fxe_q[31], fxe_q}; mul_b = {xn_q[31], xn_q}; end
					6'd1: begin mul_a = {fye_q[31], fye_q}; mul_b = {yn_q[31], yn_q}; end
					6'd4: begin mul_a = {1'b0, ax_q}; mul_b = {1'b0, ax_q}; end
					6'd5: begin mul_a = {1'b0, ay_q}; mul_b = {1'b0, ay_q}; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------------
	// shared restoring divide / square-root step
	// ------------------------------------------------------------------------
	logic        sqrt_mode;
	logic [64:0] step_t, step_s, step_d;
	logic        step_ge;

	assign sqrt_mode = (state_q == S_SQRT);
	assign step_t = sqrt_mode ? {rem_q[62:0], low_q[63:62]} : {rem_q, low_q[63]};
	assign step_s = sqrt_mode ? {29'd0, quo_q, 2'b01} : {1'b0, den_q};
	assign step_ge = (step_t >= step_s);
	assign step_d = step_t - step_s;

	// ------------------------------------------------------------------------
	// rotation numerators and misc datapath
	// ------------------------------------------------------------------------
	logic signed [63:0] num;
	logic [63:0]        num_mag;
	logic signed [63:0] s_sum;

	always_comb begin
		case (idx_q)
			4'd0: num = qp_q[0] + qp_q[1] - qp_q[2] - qp_q[3];
			4'd1: num = (qp_q[4] - qp_q[5]) <<< 1;
			4'd2: num = (qp_q[6] + qp_q[7]) <<< 1;
			4'd3: num = (qp_q[4] + qp_q[5]) <<< 1;
			4'd4: num = qp_q[0] - qp_q[1] + qp_q[2] - qp_q[3];
			4'd5: num = (qp_q[8] - qp_q[9]) <<< 1;
			4'd6: num = (qp_q[6] - qp_q[7]) <<< 1;
			4'd7: num = (qp_q[8] + qp_q[9]) <<< 1;
			4'd8: num = qp_q[0] - qp_q[1] - qp_q[2] + qp_q[3];
			default: num = '0;
		endcase
	end

	assign num_mag = num[63] ? 64'(-num) : 64'(num);
	assign s_sum = qp_q[0] + qp_q[1] + qp_q[2] + qp_q[3];

	logic signed [35:0] xc_sel;
	logic [35:0]        xc_mag;
	logic [63:0]        xc_mag64;
	logic [34:0]        quo_rnd;
	logic signed [31:0] proj_q;
	logic signed [65:0] dot_rnd;

	assign xc_sel = xc_q[idx_q[0]];
	assign xc_mag = xc_sel[35] ? 36'(-xc_sel) : 36'(xc_sel);
	assign xc_mag64 = {28'd0, xc_mag};
	assign quo_rnd = ({1'b0, quo_q} + 35'd1) >> 1;
	assign dot_rnd = rea_pkg::rshift_round(acc_q, rea_pkg::ROT_FRAC);

	always_comb begin
		if (!neg_q) begin
			if (ovf_q || quo_rnd > 35'd2147483647)
				proj_q = 32'sh7fffffff;
			else
				proj_q = quo_rnd[31:0];
		end else begin
			if (ovf_q || quo_rnd > 35'd2147483648)
				proj_q = 32'sh80000000;
			else
				proj_q = 32'(-signed'(quo_rnd));
		end
	end

	logic [65:0]        r2_full;
	logic [65:0]        sq_sum;
	logic signed [32:0] du, dv;
	logic [34:0]        root_rnd;

	assign r2_full = (66'(acc_q) + 66'(mul_q) + (66'd1 << (rea_pkg::FRAC_BITS - 1)))
		>> rea_pkg::FRAC_BITS;
	assign sq_sum = 66'(acc_q) + 66'(mul_q);
	assign du = {u_q[31], u_q} - {obs_u_q[31], obs_u_q};
	assign dv = {v_q[31], v_q} - {obs_v_q[31], obs_v_q};
	assign root_rnd = {1'b0, quo_q} + 35'((rem_q > {30'd0, quo_q}) ? 1 : 0);

	// ------------------------------------------------------------------------
	// statistics after the finishing request
	// ------------------------------------------------------------------------
	logic [31:0] chk_n, mis_n, beh_n, emin_n, emax_n;
	logic [48:0] sum_add;
	logic [47:0] sum_n;
	logic        is_chk;

	assign is_chk = (status_q == rea_pkg::STAT_CHECKED);
	assign sum_add = {1'b0, sum_q} + {17'd0, err_q};

	always_comb begin
		chk_n  = chk_q;
		mis_n  = mis_q;
		beh_n  = beh_q;
		sum_n  = sum_q;
		emin_n = emin_q;
		emax_n = emax_q;
		if (is_chk) begin
			if (chk_q != '1)
				chk_n = chk_q + 32'd1;
			sum_n = sum_add[48] ? '1 : sum_add[47:0];
			if (err_q < emin_q)
				emin_n = err_q;
			if (err_q > emax_q)
				emax_n = err_q;
		end
		if (status_q == rea_pkg::STAT_MISSING && mis_q != '1)
			mis_n = mis_q + 32'd1;
		if (status_q == rea_pkg::STAT_BEHIND && beh_q != '1)
			beh_n = beh_q + 32'd1;
	end

	logic done_go;
	assign done_go = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_model_q   <= rea_pkg::CAM_PINHOLE;
			focal_x_q     <= 31'd65536000;
			focal_y_q     <= 31'd65536000;
			principal_x_q <= '0;
			principal_y_q <= '0;
			radial_k_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rea_pkg::CFG_CAM_MODEL:   cam_model_q   <= cfg_data[1:0];
				rea_pkg::CFG_FOCAL_X:     focal_x_q     <= cfg_data[30:0];
				rea_pkg::CFG_FOCAL_Y:     focal_y_q     <= cfg_data[30:0];
				rea_pkg::CFG_PRINCIPAL_X: principal_x_q <= cfg_data;
				rea_pkg::CFG_PRINCIPAL_Y: principal_y_q <= cfg_data;
				rea_pkg::CFG_RADIAL_K:    radial_k_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// sequencer and control state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			pose_q      <= 1'b0;
			status_q    <= rea_pkg::STAT_POSE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++)
				rot_q[i] <= (i % 4 == 0) ? ROT_ONE : '0;
			t0_q   <= '0;
			t1_q   <= '0;
			t2_q   <= '0;
			chk_q  <= '0;
			mis_q  <= '0;
			beh_q  <= '0;
			sum_q  <= '0;
			emin_q <= '1;
			emax_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cnt_q  <= '0;
						idx_q  <= '0;
						pose_q <= (req.data.req_type == rea_pkg::REQ_POSE);
						if (req.data.req_type == rea_pkg::REQ_POSE) begin
							t0_q     <= req.data.vec_x;
							t1_q     <= req.data.vec_y;
							t2_q     <= req.data.vec_z;
							status_q <= rea_pkg::STAT_POSE;
							state_q  <= S_PMUL;
						end else begin
							case (req.data.track_state)
								rea_pkg::TRK_MISSING: begin
									status_q <= rea_pkg::STAT_MISSING;
									state_q  <= S_DONE;
								end
								rea_pkg::TRK_PRESENT: begin
									status_q <= rea_pkg::STAT_CHECKED;
									state_q  <= S_DOT;
								end
								default: begin
									status_q <= rea_pkg::STAT_UNTRACKED;
									state_q  <= S_DONE;
								end
							endcase
						end
					end
				end
				S_PMUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd9)
						state_q <= S_PSUM;
				end
				S_PSUM: begin
					idx_q <= '0;
					cnt_q <= '0;
					if (s_sum == '0) begin
						for (int i = 0; i < 9; i++)
							rot_q[i] <= (i % 4 == 0) ? ROT_ONE : '0;
						state_q <= S_DOT;
					end else begin
						state_q <= S_PDLD;
					end
				end
				S_PDLD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (pose_q && cnt_q == 6'(rea_pkg::ROT_STEPS - 1))
						state_q <= S_PDWR;
					else if (!pose_q && cnt_q == 6'(rea_pkg::PRJ_STEPS - 1))
						state_q <= S_ODWR;
				end
				S_PDWR: begin
					rot_q[idx_q] <= neg_q ? 32'(-signed'(quo_rnd)) : quo_rnd[31:0];
					if (idx_q == 4'd8) begin
						idx_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DOT;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= S_PDLD;
					end
				end
				S_DOT: begin
					if (cnt_q == 6'd4) begin
						cnt_q <= '0;
						if (idx_q == 4'd2) begin
							idx_q   <= '0;
							state_q <= pose_q ? S_DONE : S_ZCHK;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_ZCHK: begin
					idx_q <= '0;
					if (xc_q[2] <= 36'sd0) begin
						status_q <= rea_pkg::STAT_BEHIND;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ODLD;
					end
				end
				S_ODLD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_ODWR: begin
					cnt_q <= '0;
					if (idx_q == 4'd0) begin
						idx_q   <= 4'd1;
						state_q <= S_ODLD;
					end else begin
						state_q <= (cam_model_q == rea_pkg::CAM_RADIAL) ? S_RAD : S_PRJ;
					end
				end
				S_RAD: begin
					if (cnt_q == 6'd6) begin
						cnt_q   <= '0;
						state_q <= S_PRJ;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_PRJ: begin
					if (cnt_q == 6'd6) begin
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(rea_pkg::SQRT_STEPS - 1))
						state_q <= S_SQWR;
				end
				S_SQWR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_go) begin
						out_valid_q <= 1'b1;
						chk_q       <= chk_n;
						mis_q       <= mis_n;
						beh_q       <= beh_n;
						sum_q       <= sum_n;
						emin_q      <= emin_n;
						emax_q      <= emax_n;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		case (state_q)
			S_IDLE: begin
				qw_q      <= {req.data.quat_w[31], req.data.quat_w[31:1]};
				qx_q      <= {req.data.quat_x[31], req.data.quat_x[31:1]};
				qy_q      <= {req.data.quat_y[31], req.data.quat_y[31:1]};
				qz_q      <= {req.data.quat_z[31], req.data.quat_z[31:1]};
				pvec_q[0] <= req.data.vec_x;
				pvec_q[1] <= req.data.vec_y;
				pvec_q[2] <= req.data.vec_z;
				obs_u_q   <= req.data.obs_u;
				obs_v_q   <= req.data.obs_v;
				err_q     <= '0;
			end
			S_PMUL: begin
				qp_q[cnt_q[3:0]] <= mul_p[63:0];
			end
			S_PSUM: begin
				s_q <= s_sum;
			end
			S_PDLD: begin
				neg_q <= num[63];
				ovf_q <= 1'b0;
				rem_q <= num_mag >> rea_pkg::ROT_SHIFT;
				low_q <= num_mag << (64 - rea_pkg::ROT_SHIFT);
				den_q <= 64'(s_q);
				quo_q <= '0;
			end
			S_DIV, S_SQRT: begin
				rem_q <= step_ge ? step_d[63:0] : step_t[63:0];
				quo_q <= {quo_q[32:0], step_ge};
				low_q <= sqrt_mode ? (low_q << 2) : (low_q << 1);
			end
			S_DOT: begin
				case (cnt_q)
					6'd1: acc_q <= mul_q;
					6'd2, 6'd3: acc_q <= acc_q + mul_q;
					6'd4: begin
						if (pose_q)
							cen_q[dot_i] <= rea_pkg::sat32(-dot_rnd);
						else
							xc_q[dot_i] <= 36'(dot_rnd + 66'(tsel_i));
					end
					default: ;
				endcase
			end
			S_ODLD: begin
				neg_q <= xc_sel[35];
				ovf_q <= (xc_mag64 >> rea_pkg::PRJ_SHIFT) >= 64'(xc_q[2]);
				rem_q <= xc_mag64 >> rea_pkg::PRJ_SHIFT;
				low_q <= xc_mag64 << (64 - rea_pkg::PRJ_SHIFT);
				den_q <= 64'(xc_q[2]);
				quo_q <= '0;
			end
			S_ODWR: begin
				if (idx_q == 4'd0) begin
					xn_q <= proj_q;
				end else begin
					yn_q  <= proj_q;
					fxe_q <= {1'b0, focal_x_q};
					if (cam_model_q == rea_pkg::CAM_SIMPLE || cam_model_q == rea_pkg::CAM_RADIAL)
						fye_q <= {1'b0, focal_x_q};
					else
						fye_q <= {1'b0, focal_y_q};
				end
			end
			S_RAD: begin
				case (cnt_q)
					6'd1: acc_q <= mul_q;
					6'd2: r2_q <= (r2_full > 66'h0ffffffff) ? '1 : r2_full[31:0];
					6'd4: rad_q <= rea_pkg::sat32((66'sd1 <<< rea_pkg::FRAC_BITS)
						+ rea_pkg::rshift_round(mul_q, rea_pkg::FRAC_BITS));
					6'd6: begin
						fxe_q <= rea_pkg::sat32(rea_pkg::rshift_round(mul_q, rea_pkg::FRAC_BITS));
						fye_q <= rea_pkg::sat32(rea_pkg::rshift_round(mul_q, rea_pkg::FRAC_BITS));
					end
					default: ;
				endcase
			end
			S_PRJ: begin
				case (cnt_q)
					6'd1: u_q <= rea_pkg::sat32(rea_pkg::rshift_round(mul_q, rea_pkg::FRAC_BITS)
						+ 66'(principal_x_q));
					6'd2: v_q <= rea_pkg::sat32(rea_pkg::rshift_round(mul_q, rea_pkg::FRAC_BITS)
						+ 66'(principal_y_q));
					6'd3: begin
						ax_q <= du[32] ? 32'(-du) : du[31:0];
						ay_q <= dv[32] ? 32'(-dv) : dv[31:0];
					end
					6'd5: acc_q <= mul_q;
					6'd6: begin
						// saturate the sum of squares at all ones, then root it
						rem_q <= '0;
						low_q <= sq_sum[64] ? '1 : sq_sum[63:0];
						quo_q <= '0;
					end
					default: ;
				endcase
			end
			S_SQWR: begin
				err_q <= root_rnd[34:32] != 3'd0 ? '1 : root_rnd[31:0];
			end
			S_DONE: begin
				if (done_go) begin
					out_q.status        <= status_q;
					out_q.checked_count <= chk_n;
					out_q.missing_count <= mis_n;
					out_q.behind_count  <= beh_n;
					out_q.err_sum       <= sum_n;
					out_q.err_min       <= emin_n;
					out_q.err_max       <= emax_n;
					out_q.err_px        <= is_chk ? err_q : '0;
					if (status_q == rea_pkg::STAT_POSE) begin
						out_q.res_x <= cen_q[0];
						out_q.res_y <= cen_q[1];
						out_q.res_z <= cen_q[2];
					end else if (is_chk) begin
						out_q.res_x <= u_q;
						out_q.res_y <= v_q;
						out_q.res_z <= '0;
					end else begin
						out_q.res_x <= '0;
						out_q.res_y <= '0;
						out_q.res_z <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a request is in flight");

	a_checked_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |=> chk_q >= $past(chk_q))
		else $error("checked count went backwards");

	a_min_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		chk_q != '0 |-> emin_q <= emax_q)
		else $error("error minimum above maximum");

endmodule
